### rtl/vfnms_pkg.sv
// Shared types and fixed constants for the vector field non-maximum suppressor.
`timescale 1ns / 1ps

package vfnms_pkg;

   // Fixed field widths of the stream words.
   localparam int FIELD_BITS    = 16;
   localparam int COORD_BITS    = 10;
   localparam int CSR_DATA_BITS = 11;
   localparam int CSR_IDX_BITS  = 1;

   // Row limit of a frame.
   localparam int HEIGHT_LIMIT = 1024;
   localparam int SIZE_MIN     = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

   // Reset values of the frame size registers.
   localparam logic [CSR_DATA_BITS-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [CSR_DATA_BITS-1:0] FRAME_HEIGHT_RESET = 11'd480;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] vec_x;
      logic signed [FIELD_BITS-1:0] vec_y;
   } req_word_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] kept_x;
      logic signed [FIELD_BITS-1:0] kept_y;
      logic [COORD_BITS-1:0]        pixel_col;
      logic [COORD_BITS-1:0]        pixel_row;
      logic                         frame_end;
   } rsp_word_type;

endpackage

### rtl/vfnms_line_mem.sv
// Line store memory: one entry per column holding the two previous rows.
`timescale 1ns / 1ps

module vfnms_line_mem #(
   parameter int DEPTH     = 1024,
   parameter int DATA_BITS = 64
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_BITS-1:0]         rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_BITS-1:0]         wr_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/vfnms_window.sv
// 3x3 window of vectors with the squared components of every cell.
`timescale 1ns / 1ps

module vfnms_window #(
   parameter int COMP_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift_en,
   input  logic [COMP_BITS-1:0]     top_x,
   input  logic [COMP_BITS-1:0]     top_y,
   input  logic [COMP_BITS-1:0]     mid_x,
   input  logic [COMP_BITS-1:0]     mid_y,
   input  logic [COMP_BITS-1:0]     bot_x,
   input  logic [COMP_BITS-1:0]     bot_y,
   output logic [COMP_BITS-1:0]     centre_x,
   output logic [COMP_BITS-1:0]     centre_y,
   output logic [2*COMP_BITS-1:0]   sq_x [9],
   output logic [2*COMP_BITS-1:0]   sq_y [9]
);

   localparam int SQ_BITS = 2 * COMP_BITS;

   logic [COMP_BITS-1:0] cx_ff [9];
   logic [COMP_BITS-1:0] cy_ff [9];
   logic [SQ_BITS-1:0]   qx_ff [9];
   logic [SQ_BITS-1:0]   qy_ff [9];

   logic [COMP_BITS-1:0] new_x [3];
   logic [COMP_BITS-1:0] new_y [3];
   logic [SQ_BITS-1:0]   new_qx [3];
   logic [SQ_BITS-1:0]   new_qy [3];

   // Magnitude of a two's complement component; the most negative value maps
   // onto its unsigned magnitude, which still fits.
   function automatic logic [COMP_BITS-1:0] magnitude(input logic [COMP_BITS-1:0] v);
      return v[COMP_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [SQ_BITS-1:0] square(input logic [COMP_BITS-1:0] v);
      logic [SQ_BITS-1:0] m;
      m = SQ_BITS'(magnitude(v));
      return SQ_BITS'(m * m);
   endfunction

   always_comb begin
      new_x[0] = top_x;
      new_y[0] = top_y;
      new_x[1] = mid_x;
      new_y[1] = mid_y;
      new_x[2] = bot_x;
      new_y[2] = bot_y;
      for (int r = 0; r < 3; r++) begin
         new_qx[r] = square(new_x[r]);
         new_qy[r] = square(new_y[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            cx_ff[i] <= '0;
            cy_ff[i] <= '0;
            qx_ff[i] <= '0;
            qy_ff[i] <= '0;
         end
      end else if (shift_en) begin
         for (int r = 0; r < 3; r++) begin
            cx_ff[r*3]     <= cx_ff[r*3 + 1];
            cy_ff[r*3]     <= cy_ff[r*3 + 1];
            qx_ff[r*3]     <= qx_ff[r*3 + 1];
            qy_ff[r*3]     <= qy_ff[r*3 + 1];
            cx_ff[r*3 + 1] <= cx_ff[r*3 + 2];
            cy_ff[r*3 + 1] <= cy_ff[r*3 + 2];
            qx_ff[r*3 + 1] <= qx_ff[r*3 + 2];
            qy_ff[r*3 + 1] <= qy_ff[r*3 + 2];
            cx_ff[r*3 + 2] <= new_x[r];
            cy_ff[r*3 + 2] <= new_y[r];
            qx_ff[r*3 + 2] <= new_qx[r];
            qy_ff[r*3 + 2] <= new_qy[r];
         end
      end
   end

   assign centre_x = cx_ff[4];
   assign centre_y = cy_ff[4];
   assign sq_x     = qx_ff;
   assign sq_y     = qy_ff;

endmodule

### rtl/vfnms_decide.sv
// Direction quantization and the local maximum test for the window centre.
`timescale 1ns / 1ps

module vfnms_decide #(
   parameter int COMP_BITS = 16
) (
   input  logic                     inner,
   input  logic [COMP_BITS-1:0]     centre_x,
   input  logic [COMP_BITS-1:0]     centre_y,
   input  logic [2*COMP_BITS-1:0]   sq_x [9],
   input  logic [2*COMP_BITS-1:0]   sq_y [9],
   output logic                     keep
);

   localparam int SQ_BITS = 2 * COMP_BITS;
   localparam int S7_BITS = SQ_BITS + 3;

   logic [SQ_BITS-1:0] len_c;
   logic [SQ_BITS-1:0] len_f;
   logic [SQ_BITS-1:0] len_b;
   logic [1:0]         step_x;
   logic [1:0]         step_y;
   logic [3:0]         fwd_ix;
   logic [3:0]         back_ix;

   // Step along one axis: the sign of the component when c is nonzero and 7*c*c >= o*o.
   function automatic logic [1:0] axis_step(input logic [COMP_BITS-1:0] c,
                                            input logic [SQ_BITS-1:0]   c2,
                                            input logic [SQ_BITS-1:0]   o2);
      logic [S7_BITS-1:0] c7;
      logic               go;
      c7 = {c2, 3'b000} - S7_BITS'(c2);
      go = (c != '0) && (c7 >= S7_BITS'(o2));
      if (!go) begin
         return 2'b00;
      end
      return c[COMP_BITS-1] ? 2'b11 : 2'b01;
   endfunction

   function automatic logic [3:0] cell_ix(input logic [1:0] r, input logic [1:0] c);
      return {r, 1'b0} + 4'(r) + 4'(c);
   endfunction

   always_comb begin
      len_c   = sq_x[4] + sq_y[4];
      step_x  = axis_step(centre_x, sq_x[4], sq_y[4]);
      step_y  = axis_step(centre_y, sq_y[4], sq_x[4]);
      fwd_ix  = cell_ix(2'd1 + step_y, 2'd1 + step_x);
      back_ix = cell_ix(2'd1 - step_y, 2'd1 - step_x);
      len_f   = sq_x[fwd_ix] + sq_y[fwd_ix];
      len_b   = sq_x[back_ix] + sq_y[back_ix];
      keep    = inner && (len_c != '0) && (len_c >= len_f) && (len_c >= len_b);
   end

endmodule

### rtl/vector_field_nonmax_suppress.sv
// Top level of the vector field non-maximum suppressor.
`timescale 1ns / 1ps

//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+-------------------------------
//  req      | in        | req_valid/req_stall  | vec_x, vec_y
//  rsp      | out       | rsp_valid/rsp_stall  | kept_x, kept_y, pixel_col/row,
//           |           |                      | frame_end
//  csr      | in        | csr_we (no wait)     | csr_index, csr_data
//
// One word is taken per clock while req_stall is low. A word passes an input
// stage (line store read), the window stage (squares of the entering column)
// and the result register before its result appears. The line store, with a
// separate read and write port, and the window shift allow one word per cycle
// when nothing stalls. A synchronous reset clears counters, valid flags and the
// window; the line store is not cleared. A stalled result holds while the
// stages behind it keep draining words that produce no result; req_stall rises
// only when a result word would otherwise have to be dropped.

module vector_field_nonmax_suppress #(
   parameter int MAX_WIDTH = 1024,
   parameter int COMP_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  vfnms_pkg::req_word_type               req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output vfnms_pkg::rsp_word_type               rsp_word,
   input  logic                                  csr_we,
   input  logic [vfnms_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [vfnms_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   import vfnms_pkg::*;

   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int WB      = (CW + 1 > CSR_DATA_BITS) ? CW + 1 : CSR_DATA_BITS;
   localparam int SQ_BITS = 2 * COMP_BITS;
   localparam int VEC_BITS = 2 * COMP_BITS;

   // Frame size registers.
   logic [CSR_DATA_BITS-1:0] frame_width_ff;
   logic [CSR_DATA_BITS-1:0] frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamped frame size, expressed as the last column and the last row.
   logic [WB-1:0]            fw_ext;
   logic [WB-1:0]            width_used;
   logic [WB-1:0]            last_col;
   logic [CSR_DATA_BITS-1:0] height_used;
   logic [COORD_BITS-1:0]    last_row;

   always_comb begin
      fw_ext = WB'(frame_width_ff);
      if (fw_ext < WB'(SIZE_MIN)) begin
         width_used = WB'(SIZE_MIN);
      end else if (fw_ext > WB'(MAX_WIDTH)) begin
         width_used = WB'(MAX_WIDTH);
      end else begin
         width_used = fw_ext;
      end
      last_col = width_used - 1'b1;

      if (frame_height_ff < CSR_DATA_BITS'(SIZE_MIN)) begin
         height_used = CSR_DATA_BITS'(SIZE_MIN);
      end else if (frame_height_ff > CSR_DATA_BITS'(HEIGHT_LIMIT)) begin
         height_used = CSR_DATA_BITS'(HEIGHT_LIMIT);
      end else begin
         height_used = frame_height_ff;
      end
      last_row = COORD_BITS'(height_used - 1'b1);
   end

   // Flow control. The window may only shift once the item in the decision
   // stage has left, and that stage only waits when it holds a result word.
   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, b_free, a_free, a_go, accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign b_free    = !b_valid_ff || out_free;
   assign a_free    = !a_valid_ff || b_free;
   assign a_go      = a_valid_ff && b_free;
   assign req_stall = !a_free;
   assign accept    = req_valid && a_free;

   // Position of the next input word.
   logic [CW-1:0]         col_count_ff, col_count_in;
   logic [COORD_BITS-1:0] row_count_ff, row_count_in;
   logic                  end_row;
   logic                  end_frame;

   assign end_row   = WB'(col_count_ff) >= last_col;
   assign end_frame = end_row && (row_count_ff >= last_row);

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (end_row) begin
            col_count_in = '0;
            row_count_in = end_frame ? '0 : row_count_ff + 1'b1;
         end else begin
            col_count_in = col_count_ff + 1'b1;
         end
      end
   end

   // Input stage: the newest vector and the tags of the centre it completes.
   logic [COMP_BITS-1:0]  a_x_ff, a_y_ff;
   logic [CW-1:0]         a_col_ff;
   logic                  a_emit_ff, a_inner_ff, a_end_ff;
   logic [COORD_BITS-1:0] a_cc_ff, a_cr_ff;

   // Decision stage tags; the window itself holds the data.
   logic                  b_inner_ff, b_end_ff;
   logic [COORD_BITS-1:0] b_cc_ff, b_cr_ff;

   assign a_valid_in   = a_free ? req_valid : a_valid_ff;
   assign b_valid_in   = b_free ? (a_valid_ff && a_emit_ff) : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_x_ff     <= COMP_BITS'($unsigned(req_word.vec_x));
         a_y_ff     <= COMP_BITS'($unsigned(req_word.vec_y));
         a_col_ff   <= col_count_ff;
         a_emit_ff  <= (col_count_ff != '0) && (row_count_ff != '0);
         a_inner_ff <= (col_count_ff > CW'(1)) && (row_count_ff > COORD_BITS'(1));
         a_end_ff   <= end_frame;
         a_cc_ff    <= COORD_BITS'(col_count_ff - 1'b1);
         a_cr_ff    <= row_count_ff - 1'b1;
      end
      if (a_go) begin
         b_inner_ff <= a_inner_ff;
         b_end_ff   <= a_end_ff;
         b_cc_ff    <= a_cc_ff;
         b_cr_ff    <= a_cr_ff;
      end
   end

   // Line store: each entry keeps {row-2, row-1} of one column, each vector as
   // {y, x}. The entry is read on accept and rewritten once its word leaves the input stage.
   logic [2*VEC_BITS-1:0] line_rd;
   logic [2*VEC_BITS-1:0] line_wr;

   assign line_wr = {line_rd[VEC_BITS-1:0], a_y_ff, a_x_ff};

   vfnms_line_mem #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (2 * VEC_BITS)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_count_ff),
      .rd_data (line_rd),
      .wr_en   (a_go),
      .wr_addr (a_col_ff),
      .wr_data (line_wr)
   );

   // Window shift with the column of the word in the input stage.
   logic [COMP_BITS-1:0] centre_x, centre_y;
   logic [SQ_BITS-1:0]   sq_x [9];
   logic [SQ_BITS-1:0]   sq_y [9];

   vfnms_window #(
      .COMP_BITS (COMP_BITS)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (a_go),
      .top_x    (line_rd[VEC_BITS +: COMP_BITS]),
      .top_y    (line_rd[VEC_BITS + COMP_BITS +: COMP_BITS]),
      .mid_x    (line_rd[0 +: COMP_BITS]),
      .mid_y    (line_rd[COMP_BITS +: COMP_BITS]),
      .bot_x    (a_x_ff),
      .bot_y    (a_y_ff),
      .centre_x (centre_x),
      .centre_y (centre_y),
      .sq_x     (sq_x),
      .sq_y     (sq_y)
   );

   // Local maximum test on the current window.
   logic keep;

   vfnms_decide #(
      .COMP_BITS (COMP_BITS)
   ) u_decide (
      .inner    (b_inner_ff),
      .centre_x (centre_x),
      .centre_y (centre_y),
      .sq_x     (sq_x),
      .sq_y     (sq_y),
      .keep     (keep)
   );

   // Result register. The kept components are the raw component bits,
   // zero-extended or cut to the field width.
   rsp_word_type rsp_word_ff;
   logic         load_rsp;

   assign load_rsp     = b_valid_ff && out_free;
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_word_ff.kept_x    <= keep ? FIELD_BITS'(centre_x) : '0;
         rsp_word_ff.kept_y    <= keep ? FIELD_BITS'(centre_y) : '0;
         rsp_word_ff.pixel_col <= b_cc_ff;
         rsp_word_ff.pixel_row <= b_cr_ff;
         rsp_word_ff.frame_end <= b_end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The line store is never read and rewritten at one column in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && a_go) |-> (a_col_ff != col_count_ff))
      else $error("line store read and write hit the same column");

   // The column counter never leaves the line store.
   assert property (@(posedge clock) disable iff (reset)
      (WB'(col_count_ff) < WB'(MAX_WIDTH)))
      else $error("column counter beyond line store depth");

   // The row only moves at the end of a row.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !end_row) |=> $stable(row_count_ff))
      else $error("row advanced inside a row");

   // A result word waiting in the decision stage is not lost.
   assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !out_free) |=> (b_valid_ff && $stable(b_cc_ff) && $stable(b_cr_ff)))
      else $error("pending result dropped from the decision stage");

endmodule
